[sv/dds_pkg.sv]
// Shared types and constants for the deadlock detection scan block.
// Holds the request and result payload structs, command codes and table sizes.
// No dependencies; the design files use it by scoped names, the testbench imports it.
package dds_pkg;

   localparam int MAX_ENTRIES   = 16;
   localparam int MAX_RESOURCES = 8;

   localparam int ENTRY_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int RES_W   = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;

   localparam int COUNT_W       = 16;
   localparam int ENT_CFG_W     = 5;
   localparam int RES_CFG_W     = 4;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENTRIES_IN_USE   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESOURCES_IN_USE = 1'd1;

   typedef enum logic [2:0] {
      CMD_WR_REQUEST = 3'd0,
      CMD_WR_ALLOC   = 3'd1,
      CMD_WR_AVAIL   = 3'd2,
      CMD_CLR_MARKS  = 3'd3,
      CMD_SCAN_STEP  = 3'd4,
      CMD_QUERY      = 3'd5,
      CMD_RD_AVAIL   = 3'd6
   } cmd_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [3:0]  entry_index;
      logic [2:0]  resource_index;
      logic [15:0] value;
   } req_payload_type;

   typedef struct packed {
      logic        found;
      logic [3:0]  found_index;
      logic        is_marked;
      logic        alloc_all_zero;
      logic [15:0] read_value;
   } rsp_payload_type;

   // Live configuration, already clamped to the table sizes.
   typedef struct packed {
      logic [ENT_CFG_W-1:0] entries;
      logic [RES_CFG_W-1:0] resources;
   } cfg_type;

   // One table row: all resource counts of one entry.
   typedef logic [MAX_RESOURCES-1:0][COUNT_W-1:0] row_type;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_SCAN = 5'b00010,
      S_REL  = 5'b00100,
      S_QRY  = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

endpackage

[sv/dds_row_ram.sv]
// Row-wide table memory: one entry per row, one count per resource lane.
// Writes one lane per cycle and reads a whole row into a read register.
// Depends on dds_pkg for the table sizes and the row type.
module dds_row_ram (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [dds_pkg::ENTRY_W-1:0] wr_row,
   input  logic [dds_pkg::RES_W-1:0]   wr_lane,
   input  logic [dds_pkg::COUNT_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [dds_pkg::ENTRY_W-1:0] rd_row,
   output dds_pkg::row_type            rd_data
);

   dds_pkg::row_type mem [dds_pkg::MAX_ENTRIES];
   dds_pkg::row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_row][wr_lane] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_row];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/dds_core.sv]
// Command sequencer of the deadlock detection scan: marks, available counts
// and the request and allocation tables (two dds_row_ram instances).
// Depends on dds_pkg and dds_row_ram.
module dds_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  dds_pkg::req_payload_type req_payload,
   output logic                     req_stall,
   input  dds_pkg::cfg_type         cfg,
   output logic                     res_valid,
   input  logic                     res_ready,
   output dds_pkg::rsp_payload_type res_payload
);

   dds_pkg::state_type state_ff, state_in;
   logic [dds_pkg::ENTRY_W-1:0] idx_ff, idx_in;
   logic [dds_pkg::MAX_ENTRIES-1:0] mark_ff, mark_in;
   logic [dds_pkg::COUNT_W-1:0] avail_ff [dds_pkg::MAX_RESOURCES];
   logic [dds_pkg::COUNT_W-1:0] avail_in [dds_pkg::MAX_RESOURCES];
   dds_pkg::rsp_payload_type res_ff, res_in;
   logic qry_ok_ff, qry_ok_in;

   logic                        rd_en;
   logic [dds_pkg::ENTRY_W-1:0] rd_row;
   logic                        req_we;
   logic                        alloc_we;
   logic [dds_pkg::ENTRY_W-1:0] wr_row;
   logic [dds_pkg::RES_W-1:0]   wr_lane;
   dds_pkg::row_type            req_row;
   dds_pkg::row_type            alloc_row;

   logic accept;
   logic e_ok;
   logic r_ok;
   logic fits;
   logic hit;
   logic all_zero;
   logic [dds_pkg::COUNT_W:0] sum [dds_pkg::MAX_RESOURCES];

   dds_row_ram u_req_ram (
      .clock   (clock),
      .wr_en   (req_we),
      .wr_row  (wr_row),
      .wr_lane (wr_lane),
      .wr_data (req_payload.value),
      .rd_en   (rd_en),
      .rd_row  (rd_row),
      .rd_data (req_row)
   );

   dds_row_ram u_alloc_ram (
      .clock   (clock),
      .wr_en   (alloc_we),
      .wr_row  (wr_row),
      .wr_lane (wr_lane),
      .wr_data (req_payload.value),
      .rd_en   (rd_en),
      .rd_row  (rd_row),
      .rd_data (alloc_row)
   );

   assign req_stall = (state_ff != dds_pkg::S_IDLE);
   assign accept    = req_valid && (state_ff == dds_pkg::S_IDLE);
   assign e_ok      = int'(req_payload.entry_index) < dds_pkg::MAX_ENTRIES;
   assign r_ok      = int'(req_payload.resource_index) < dds_pkg::MAX_RESOURCES;
   assign wr_row    = dds_pkg::ENTRY_W'(req_payload.entry_index);
   assign wr_lane   = dds_pkg::RES_W'(req_payload.resource_index);

   // All resource lanes in use are compared at once against the row just read.
   always_comb begin
      fits     = 1'b1;
      all_zero = 1'b1;
      for (int k = 0; k < dds_pkg::MAX_RESOURCES; k++) begin
         if (k < int'(cfg.resources)) begin
            if (req_row[k] > avail_ff[k]) begin
               fits = 1'b0;
            end
            if (alloc_row[k] != '0) begin
               all_zero = 1'b0;
            end
         end
         sum[k] = {1'b0, avail_ff[k]} + {1'b0, alloc_row[k]};
      end
   end

   assign hit = !mark_ff[idx_ff] && fits;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      mark_in   = mark_ff;
      avail_in  = avail_ff;
      res_in    = res_ff;
      qry_ok_in = qry_ok_ff;
      rd_en     = 1'b0;
      rd_row    = '0;
      req_we    = 1'b0;
      alloc_we  = 1'b0;

      case (state_ff)
         dds_pkg::S_IDLE: begin
            if (accept) begin
               res_in   = '0;
               state_in = dds_pkg::S_DONE;
               case (dds_pkg::cmd_type'(req_payload.cmd))
                  dds_pkg::CMD_WR_REQUEST: begin
                     req_we = e_ok && r_ok;
                  end
                  dds_pkg::CMD_WR_ALLOC: begin
                     alloc_we = e_ok && r_ok;
                  end
                  dds_pkg::CMD_WR_AVAIL: begin
                     if (r_ok) begin
                        avail_in[wr_lane] = req_payload.value;
                     end
                  end
                  dds_pkg::CMD_CLR_MARKS: begin
                     mark_in = '0;
                  end
                  dds_pkg::CMD_SCAN_STEP: begin
                     if (cfg.entries != '0) begin
                        rd_en    = 1'b1;
                        rd_row   = '0;
                        idx_in   = '0;
                        state_in = dds_pkg::S_SCAN;
                     end
                  end
                  dds_pkg::CMD_QUERY: begin
                     rd_en     = 1'b1;
                     rd_row    = wr_row;
                     idx_in    = wr_row;
                     qry_ok_in = e_ok;
                     state_in  = dds_pkg::S_QRY;
                  end
                  dds_pkg::CMD_RD_AVAIL: begin
                     if (r_ok) begin
                        res_in.read_value = avail_ff[wr_lane];
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         dds_pkg::S_SCAN: begin
            // The row of idx_ff is on the read port; the next row is fetched
            // only when this one does not qualify, so a hit keeps its
            // allocation row in the read register for the release cycle.
            if (hit) begin
               mark_in[idx_ff]   = 1'b1;
               res_in.found       = 1'b1;
               res_in.found_index = 4'(idx_ff);
               state_in           = dds_pkg::S_REL;
            end else if (int'(idx_ff) + 1 < int'(cfg.entries)) begin
               rd_en  = 1'b1;
               rd_row = idx_ff + 1'b1;
               idx_in = idx_ff + 1'b1;
            end else begin
               state_in = dds_pkg::S_DONE;
            end
         end
         dds_pkg::S_REL: begin
            for (int k = 0; k < dds_pkg::MAX_RESOURCES; k++) begin
               if (k < int'(cfg.resources)) begin
                  avail_in[k] = sum[k][dds_pkg::COUNT_W] ? '1 : sum[k][dds_pkg::COUNT_W-1:0];
               end
            end
            state_in = dds_pkg::S_DONE;
         end
         dds_pkg::S_QRY: begin
            res_in.is_marked      = qry_ok_ff && mark_ff[idx_ff];
            res_in.alloc_all_zero = !qry_ok_ff || all_zero;
            state_in              = dds_pkg::S_DONE;
         end
         dds_pkg::S_DONE: begin
            if (res_ready) begin
               state_in = dds_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = dds_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dds_pkg::S_IDLE;
         mark_ff  <= '0;
         for (int k = 0; k < dds_pkg::MAX_RESOURCES; k++) begin
            avail_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         mark_ff  <= mark_in;
         avail_ff <= avail_in;
      end
      idx_ff    <= idx_in;
      res_ff    <= res_in;
      qry_ok_ff <= qry_ok_in;
   end

   assign res_valid   = (state_ff == dds_pkg::S_DONE);
   assign res_payload = res_ff;

endmodule

[sv/deadlock_detection_scan.sv]
// Deadlock detection scan, usage notes.
//
// Requests enter on req_valid/req_stall/req_payload; a request is taken at a
// rising edge with req_valid high and req_stall low. Every request gives
// exactly one response on rsp_valid/rsp_stall/rsp_payload, in order.
// Requests are worked one at a time. Writes, clear, read and unused codes
// go from acceptance to the done state, a query through a query state, and a
// scan step reads table rows in order, at most the live entry count (16
// here): the request and allocation memories give one row per cycle and all
// resources in use of a row are compared in the same cycle. A found entry
// then passes a release state that adds its allocation to the available
// counts. The next request can be taken at the edge where the response
// can first be taken.
// A response waiting in the output register does not keep the next request
// out; a stalled response holds its payload until taken.
// Configuration: csr_we writes csr_wdata into register csr_index (0 entries
// in use, 1 resources in use) and is meant for an idle block.
// Synchronous reset clears marks, available counts, the configuration
// registers and all handshake state; the table memories are not cleared.
// Depends on dds_pkg and dds_core.
module deadlock_detection_scan (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  dds_pkg::req_payload_type         req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output dds_pkg::rsp_payload_type         rsp_payload,
   input  logic                             csr_we,
   input  logic [dds_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [dds_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic [dds_pkg::ENT_CFG_W-1:0] entries_ff;
   logic [dds_pkg::RES_CFG_W-1:0] resources_ff;
   dds_pkg::cfg_type cfg;

   logic                     res_valid;
   logic                     res_ready;
   dds_pkg::rsp_payload_type res_payload;

   logic                     rsp_valid_ff, rsp_valid_in;
   dds_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff   <= '0;
         resources_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            dds_pkg::CSR_ENTRIES_IN_USE: begin
               entries_ff <= csr_wdata[dds_pkg::ENT_CFG_W-1:0];
            end
            dds_pkg::CSR_RESOURCES_IN_USE: begin
               resources_ff <= csr_wdata[dds_pkg::RES_CFG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Counts above the table sizes are clamped once here.
   always_comb begin
      cfg.entries = entries_ff;
      if (int'(entries_ff) > dds_pkg::MAX_ENTRIES) begin
         cfg.entries = dds_pkg::ENT_CFG_W'(dds_pkg::MAX_ENTRIES);
      end
      cfg.resources = resources_ff;
      if (int'(resources_ff) > dds_pkg::MAX_RESOURCES) begin
         cfg.resources = dds_pkg::RES_CFG_W'(dds_pkg::MAX_RESOURCES);
      end
   end

   dds_core u_core (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .cfg         (cfg),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_payload (res_payload)
   );

   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (res_ready) begin
         rsp_valid_in   = res_valid;
         rsp_payload_in = res_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

[sv/dds_checker.sv]
// Port-level assertions for the deadlock detection scan, and their binding.
// Sees only the top-level ports; depends on dds_pkg.
module dds_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input dds_pkg::req_payload_type        req_payload,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input dds_pkg::rsp_payload_type        rsp_payload,
   input logic                            csr_we,
   input logic [dds_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [dds_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // No response may appear right after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Requests are worked one at a time, so an accepted request closes the input.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request accepted while one is in work");

   // A stalled response must hold.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // A scan result never shares one response with query or read results.
   a_fields_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.found && (rsp_payload.is_marked ||
                      rsp_payload.alloc_all_zero || rsp_payload.read_value != '0)))
      else $error("scan result mixed with other fields");

   // An index is only reported with a found entry.
   a_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.found |-> rsp_payload.found_index == '0)
      else $error("index reported without a found entry");

endmodule

bind deadlock_detection_scan dds_checker u_dds_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload),
   .csr_we      (csr_we),
   .csr_index   (csr_index),
   .csr_wdata   (csr_wdata)
);

[test/tb_deadlock_detection_scan.sv]
// Self-checking testbench for deadlock_detection_scan: directed and random command
// streams, with a transaction-level predictor of the request and allocation tables,
// marks and available counts. Depends on dds_pkg and the deadlock_detection_scan RTL.
module tb_deadlock_detection_scan;
   import dds_pkg::*;

   localparam logic [2:0] CMD_UNUSED = 3'd7;
   localparam int ITEM_GOAL = 1650;
   localparam int CYCLE_LIMIT = 500000;
   localparam int SETTLE_CYCLES = 25;
   localparam int LONG_HOLD = 80;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Predictor state.
   logic [COUNT_W-1:0] need_units [MAX_ENTRIES][MAX_RESOURCES];
   logic [COUNT_W-1:0] held_units [MAX_ENTRIES][MAX_RESOURCES];
   logic [COUNT_W-1:0] free_units [MAX_RESOURCES];
   logic [MAX_ENTRIES-1:0] marked;
   logic [ENT_CFG_W-1:0] cfg_entries;
   logic [RES_CFG_W-1:0] cfg_resources;

   req_payload_type pending_q[$];
   rsp_payload_type expect_q[$];
   int n_queued = 0;
   int n_taken = 0;
   int errors = 0;
   int cycles = 0;
   int idle_mode = 0;
   int hold_asks = 0;
   int hold_seen = 0;
   int hold_left = 0;
   logic req_taken = 1'b0;

   deadlock_detection_scan DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic rsp_payload_type apply_command(input req_payload_type p);
      rsp_payload_type res;
      int ne;
      int nr;
      logic hit;
      logic fits;
      logic [COUNT_W:0] sum;
      res = '0;
      hit = 1'b0;
      ne = (int'(cfg_entries) > MAX_ENTRIES) ? MAX_ENTRIES : int'(cfg_entries);
      nr = (int'(cfg_resources) > MAX_RESOURCES) ? MAX_RESOURCES : int'(cfg_resources);
      case (p.cmd)
         CMD_WR_REQUEST: need_units[p.entry_index][p.resource_index] = p.value;
         CMD_WR_ALLOC: held_units[p.entry_index][p.resource_index] = p.value;
         CMD_WR_AVAIL: free_units[p.resource_index] = p.value;
         CMD_CLR_MARKS: marked = '0;
         CMD_SCAN_STEP: begin
            for (int i = 0; i < ne; i++) begin
               fits = !hit && !marked[i];
               for (int r = 0; r < nr; r++) begin
                  if (need_units[i][r] > free_units[r]) fits = 1'b0;
               end
               if (fits) begin
                  hit = 1'b1;
                  marked[i] = 1'b1;
                  // Released units saturate at the largest count.
                  for (int r = 0; r < nr; r++) begin
                     sum = {1'b0, free_units[r]} + {1'b0, held_units[i][r]};
                     free_units[r] = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
                  end
                  res.found = 1'b1;
                  res.found_index = i[3:0];
               end
            end
         end
         CMD_QUERY: begin
            res.is_marked = marked[p.entry_index];
            res.alloc_all_zero = 1'b1;
            for (int r = 0; r < nr; r++) begin
               if (held_units[p.entry_index][r] != 0) res.alloc_all_zero = 1'b0;
            end
         end
         CMD_RD_AVAIL: res.read_value = free_units[p.resource_index];
         default: ;
      endcase
      return res;
   endfunction

   task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
         errors++;
      end
   endtask

   // Request acceptance, prediction and response checking.
   always @(posedge clock) begin : watch
      rsp_payload_type want;
      req_taken = req_valid && !req_stall;
      if (reset) begin
         marked = '0;
         cfg_entries = '0;
         cfg_resources = '0;
         for (int r = 0; r < MAX_RESOURCES; r++) free_units[r] = '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ENTRIES_IN_USE: cfg_entries = csr_wdata[ENT_CFG_W-1:0];
               CSR_RESOURCES_IN_USE: cfg_resources = csr_wdata[RES_CFG_W-1:0];
               default: ;
            endcase
         end
         if (req_taken) begin
            expect_q.push_back(apply_command(req_payload));
            n_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expect_q.size() == 0) begin
               $display("%0t: response with none expected, actual %p", $time, rsp_payload);
               errors++;
            end else begin
               want = expect_q.pop_front();
               check_field("found", 16'(want.found), 16'(rsp_payload.found));
               check_field("found_index", 16'(want.found_index),
                           16'(rsp_payload.found_index));
               check_field("is_marked", 16'(want.is_marked), 16'(rsp_payload.is_marked));
               check_field("alloc_all_zero", 16'(want.alloc_all_zero),
                           16'(rsp_payload.alloc_all_zero));
               check_field("read_value", want.read_value, rsp_payload.read_value);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Request driver: a new request goes out only once the current one was taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_q.size() > 0 &&
             !(idle_mode == 0 && $urandom_range(0, 99) < 13) &&
             !(idle_mode == 1 && $urandom_range(0, 99) < 88)) begin
            req_valid <= 1'b1;
            req_payload <= pending_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response back-pressure, with one long hold-off on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_asks) begin
         hold_seen <= hold_asks;
         hold_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else begin
         case (idle_mode)
            0: rsp_stall <= ($urandom_range(0, 99) < 88);
            1: rsp_stall <= ($urandom_range(0, 99) < 13);
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   task automatic queue_command(input logic [2:0] cmd, input int e, input int r,
                                input logic [15:0] v);
      req_payload_type item;
      item.cmd = cmd;
      item.entry_index = e[3:0];
      item.resource_index = r[2:0];
      item.value = v;
      pending_q.push_back(item);
      n_queued++;
   endtask

   function automatic logic [15:0] pick_count();
      case ($urandom_range(0, 9))
         0: return 16'hFFFF;
         1: return 16'($urandom);
         2: return 16'h0000;
         default: return 16'($urandom_range(1, 7));
      endcase
   endfunction

   task automatic wait_for_quiet();
      while (n_taken != n_queued || expect_q.size() != 0) @(negedge clock);
   endtask

   task automatic reconfigure(input logic [4:0] ent_w, input logic [4:0] res_w);
      wait_for_quiet();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we = 1'b1;
      csr_index = CSR_ENTRIES_IN_USE;
      csr_wdata = ent_w;
      @(negedge clock);
      csr_index = CSR_RESOURCES_IN_USE;
      csr_wdata = res_w;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // One setting, some table updates, scan steps to exhaust the table, queries and reads.
   task automatic run_scenario();
      int ne;
      int nr;
      int le;
      int lr;
      case ($urandom_range(0, 9))
         0: ne = 0;
         1: ne = $urandom_range(17, 31);
         default: ne = $urandom_range(1, 16);
      endcase
      case ($urandom_range(0, 9))
         0: nr = 0;
         1: nr = $urandom_range(9, 15);
         default: nr = $urandom_range(1, 8);
      endcase
      reconfigure(ne[4:0], {1'($urandom_range(0, 1)), nr[3:0]});
      le = (ne > MAX_ENTRIES) ? MAX_ENTRIES : ne;
      lr = (nr > MAX_RESOURCES) ? MAX_RESOURCES : nr;
      for (int r = 0; r < lr; r++) begin
         if ($urandom_range(0, 3) != 0) queue_command(CMD_WR_AVAIL, 0, r, pick_count());
      end
      repeat ($urandom_range(0, 10)) begin
         queue_command($urandom_range(0, 1) ? CMD_WR_REQUEST : CMD_WR_ALLOC,
                       $urandom_range(0, (le > 0) ? le - 1 : 15),
                       $urandom_range(0, (lr > 0) ? lr - 1 : 7), pick_count());
      end
      if ($urandom_range(0, 9) != 0) queue_command(CMD_CLR_MARKS, 0, 0, 16'h0);
      for (int k = 0; k <= le; k++) begin
         queue_command(CMD_SCAN_STEP, 0, 0, 16'h0);
         if ($urandom_range(0, 4) == 0) begin
            queue_command(3'($urandom_range(0, 7)), $urandom_range(0, 15),
                          $urandom_range(0, 7), 16'($urandom));
         end
      end
      repeat ($urandom_range(1, 4)) begin
         queue_command(CMD_QUERY, $urandom_range(0, 15), 0, 16'h0);
         queue_command(CMD_RD_AVAIL, 0, $urandom_range(0, 7), 16'h0);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Fresh block: no entries in use, so nothing reads the tables yet.
      queue_command(CMD_RD_AVAIL, 0, 3, 16'h0);
      queue_command(CMD_UNUSED, 15, 7, 16'hFFFF);
      queue_command(CMD_CLR_MARKS, 0, 0, 16'h0);
      queue_command(CMD_SCAN_STEP, 0, 0, 16'h0);

      // Every table cell gets a value before any scan or query can reach it.
      for (int e = 0; e < MAX_ENTRIES; e++) begin
         for (int r = 0; r < MAX_RESOURCES; r++) begin
            queue_command(CMD_WR_REQUEST, e, r, pick_count());
            queue_command(CMD_WR_ALLOC, e, r, pick_count());
         end
      end

      // Registers above their bounds are clamped to the table size.
      reconfigure(5'd31, 5'd15);
      queue_command(CMD_CLR_MARKS, 0, 0, 16'h0);
      queue_command(CMD_SCAN_STEP, 0, 0, 16'h0);
      queue_command(CMD_SCAN_STEP, 0, 0, 16'h0);
      queue_command(CMD_QUERY, 0, 0, 16'h0);
      queue_command(CMD_QUERY, 15, 0, 16'h0);
      queue_command(CMD_WR_AVAIL, 0, 7, 16'hFFFF);
      queue_command(CMD_RD_AVAIL, 0, 7, 16'h0);
      queue_command(CMD_RD_AVAIL, 0, 0, 16'h0);

      // A single resource: releasing a full allocation into a full count saturates.
      reconfigure(5'd16, 5'd1);
      queue_command(CMD_WR_AVAIL, 0, 0, 16'hFFFF);
      queue_command(CMD_WR_ALLOC, 0, 0, 16'hFFFF);
      queue_command(CMD_WR_REQUEST, 15, 0, 16'h0000);
      queue_command(CMD_CLR_MARKS, 0, 0, 16'h0);
      queue_command(CMD_SCAN_STEP, 0, 0, 16'h0);
      queue_command(CMD_RD_AVAIL, 0, 0, 16'h0);
      queue_command(CMD_QUERY, 0, 0, 16'h0);
      queue_command(CMD_WR_ALLOC, 1, 0, 16'h0000);
      queue_command(CMD_QUERY, 1, 0, 16'h0);

      // No resources in use: every unmarked entry qualifies.
      reconfigure(5'd16, 5'd0);
      queue_command(CMD_CLR_MARKS, 0, 0, 16'h0);
      queue_command(CMD_SCAN_STEP, 0, 0, 16'h0);
      queue_command(CMD_SCAN_STEP, 0, 0, 16'h0);
      queue_command(CMD_QUERY, 3, 0, 16'h0);

      // No entries in use: a scan step finds nothing.
      reconfigure(5'd0, 5'd8);
      queue_command(CMD_SCAN_STEP, 0, 0, 16'h0);
      queue_command(CMD_QUERY, 15, 0, 16'h0);

      while (n_queued < ITEM_GOAL) begin
         idle_mode = (n_queued < ITEM_GOAL / 3) ? 0 : (n_queued < 2 * ITEM_GOAL / 3) ? 1 : 2;
         run_scenario();
         if (idle_mode == 2 && hold_asks == 0) hold_asks = 1;
      end

      wait_for_quiet();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
